/* hdl/c8v_pkg.sv */
// shared types, lookup tables and constants for the cesu-8 stream validator
`default_nettype none

package c8v_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned TAIL_W = 3;
	localparam int unsigned HIST_W = 3;

	localparam logic [3:0] NIB_ILLEGAL = 4'hF;
	localparam logic [3:0] NIB_THREE_BYTE = 4'hE;
	localparam logic [1:0] TOP_LEAD = 2'b11;

	localparam logic [TAIL_W-1:0] TAIL_NONE = 3'd0;
	localparam logic [TAIL_W-1:0] TAIL_LEAD = 3'd1;
	localparam logic [TAIL_W-1:0] TAIL_THREE = 3'd2;
	localparam logic [TAIL_W-1:0] TAIL_HS_CUR = 3'd3;
	localparam logic [TAIL_W-1:0] TAIL_HS_BACK1 = 3'd4;
	localparam logic [TAIL_W-1:0] TAIL_HS_BACK2 = 3'd5;

	localparam logic [2:0] MARK_BACK2 = 3'b100;
	localparam logic [2:0] MARK_BACK1 = 3'b010;
	localparam logic [2:0] MARK_CUR = 3'b001;

	localparam logic [BYTE_W-1:0] CUR_HI_TAB [16] = '{
		8'h33, 8'h33, 8'h33, 8'h33, 8'h33, 8'h33, 8'h33, 8'h33,
		8'h3C, 8'h3C, 8'h3C, 8'h3C, 8'h33, 8'h33, 8'h33, 8'h00
	};
	localparam logic [BYTE_W-1:0] BACK1_HI_TAB [16] = '{
		8'h14, 8'h14, 8'h14, 8'h14, 8'h14, 8'h14, 8'h14, 8'h14,
		8'h3A, 8'h3A, 8'h9A, 8'h5A, 8'h11, 8'h11, 8'h11, 8'h00
	};
	localparam logic [BYTE_W-1:0] BACK2_HI_TAB [16] = '{
		8'h05, 8'h05, 8'h05, 8'h05, 8'h05, 8'h05, 8'h05, 8'h05,
		8'h0D, 8'h0D, 8'h0D, 8'h0D, 8'h1D, 8'h0D, 8'hE7, 8'h00
	};
	localparam logic [BYTE_W-1:0] BACK2_LO_TAB [16] = '{
		8'h3F, 8'h1F, 8'h0F, 8'h0F, 8'h0F, 8'h0F, 8'h0F, 8'h0F,
		8'h0F, 8'h0F, 8'h0F, 8'h0F, 8'h0F, 8'hCF, 8'h0F, 8'h0F
	};

	typedef struct packed {
		logic                err;
		logic                hi_mark;
		logic [TAIL_W-1:0]   open_tail;
	} check_t;

endpackage

`default_nettype wire

/* hdl/c8v_check.sv */
// per-byte nibble lookup check, surrogate pairing and tail length
`default_nettype none

module c8v_check (
	input  wire logic [c8v_pkg::BYTE_W-1:0] cur_byte,
	input  wire logic [c8v_pkg::BYTE_W-1:0] prev_byte,
	input  wire logic [c8v_pkg::BYTE_W-1:0] prev_prev_byte,
	input  wire logic [c8v_pkg::HIST_W-1:0] hs_hist,
	output c8v_pkg::check_t                 res
);

	logic [c8v_pkg::BYTE_W-1:0] r3;
	logic [c8v_pkg::BYTE_W-1:0] part;
	logic                       lo_mark;
	logic [2:0]                 marks;

	always_comb begin
		r3 = c8v_pkg::CUR_HI_TAB[cur_byte[7:4]];
		part = c8v_pkg::BACK1_HI_TAB[prev_byte[7:4]]
			& c8v_pkg::BACK2_HI_TAB[prev_prev_byte[7:4]]
			& c8v_pkg::BACK2_LO_TAB[prev_prev_byte[3:0]];
		res.hi_mark = part[7];
		lo_mark = part[6];
		res.err = ((part & r3) != '0)
			|| (cur_byte[7:4] == c8v_pkg::NIB_ILLEGAL)
			|| (hs_hist[2] != lo_mark);
		marks = {hs_hist[1], hs_hist[0], part[7]};
		if (marks == c8v_pkg::MARK_BACK2) begin
			res.open_tail = c8v_pkg::TAIL_HS_BACK2;
		end else if (marks == c8v_pkg::MARK_BACK1) begin
			res.open_tail = c8v_pkg::TAIL_HS_BACK1;
		end else if (marks == c8v_pkg::MARK_CUR) begin
			res.open_tail = c8v_pkg::TAIL_HS_CUR;
		end else if (prev_byte[7:4] == c8v_pkg::NIB_THREE_BYTE) begin
			res.open_tail = c8v_pkg::TAIL_THREE;
		end else if (cur_byte[7:6] == c8v_pkg::TOP_LEAD) begin
			res.open_tail = c8v_pkg::TAIL_LEAD;
		end else begin
			res.open_tail = c8v_pkg::TAIL_NONE;
		end
	end

endmodule

`default_nettype wire

/* hdl/cesu8_stream_validator.sv */
// top level of the cesu-8 stream validator
//
// channel  dir  tdata (low bit up)                      tuser  tlast
// s_axis   in   data_byte[7:0]                          -      last_byte
// m_axis   out  stream_valid, open_tail[2:0], 4'b0      -      -
//
// one byte per cycle unless a last byte waits on a stalled result; a byte is
// registered, checked combinationally against the two bytes before it, and a
// result beat is registered on the last byte.
// reset clears the byte history, surrogate marks and the sticky error.
// a stalled result holds only the last byte of a stream; other bytes keep flowing.
`default_nettype none

module cesu8_stream_validator (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_axis_tvalid,
	output logic            s_axis_tready,
	input  wire logic [7:0] s_axis_tdata,   // data_byte[7:0]
	input  wire logic       s_axis_tlast,   // last_byte
	output logic            m_axis_tvalid,
	input  wire logic       m_axis_tready,
	output logic [7:0]      m_axis_tdata    // stream_valid, open_tail[2:0], zero pad
);

	logic                             valid_s1;
	logic [c8v_pkg::BYTE_W-1:0]       byte_s1;
	logic                             last_s1;
	logic [c8v_pkg::BYTE_W-1:0]       prev_q;
	logic [c8v_pkg::BYTE_W-1:0]       prev_prev_q;
	logic [c8v_pkg::HIST_W-1:0]       hist_q;
	logic                             err_q;
	logic                             out_valid_q;
	logic                             stream_valid_q;
	logic [c8v_pkg::TAIL_W-1:0]       open_tail_q;
	logic                             out_free;
	logic                             advance;
	c8v_pkg::check_t                  chk;

	c8v_check u_check (
		.cur_byte       (byte_s1),
		.prev_byte      (prev_q),
		.prev_prev_byte (prev_prev_q),
		.hs_hist        (hist_q),
		.res            (chk)
	);

	assign out_free = !out_valid_q || m_axis_tready;
	assign advance = valid_s1 && (!last_s1 || out_free);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	// history and sticky error, cleared after the last byte of a stream
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			prev_prev_q <= '0;
			hist_q <= '0;
			err_q <= 1'b0;
		end else if (advance) begin
			if (last_s1) begin
				prev_q <= '0;
				prev_prev_q <= '0;
				hist_q <= '0;
				err_q <= 1'b0;
			end else begin
				prev_q <= byte_s1;
				prev_prev_q <= prev_q;
				hist_q <= {hist_q[c8v_pkg::HIST_W-2:0], chk.hi_mark};
				err_q <= err_q | chk.err;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			stream_valid_q <= !(err_q | chk.err);
			open_tail_q <= chk.open_tail;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {4'b0000, open_tail_q, stream_valid_q};

endmodule

`default_nettype wire

/* bench/cesu8_stream_validator_tb.sv */
// testbench for the cesu-8 stream validator: random and directed byte streams, scoreboarded
`timescale 1ns / 100ps

module cesu8_stream_validator_tb;

	localparam int ITEMS_GOAL = 1950;
	localparam int LIMIT_CYCLES = 400000;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 20;
	localparam int REPORT_MAX = 10;

	localparam logic [7:0] LUT_CUR [16] = '{
		8'h33, 8'h33, 8'h33, 8'h33, 8'h33, 8'h33, 8'h33, 8'h33,
		8'h3C, 8'h3C, 8'h3C, 8'h3C, 8'h33, 8'h33, 8'h33, 8'h00
	};
	localparam logic [7:0] LUT_BACK1 [16] = '{
		8'h14, 8'h14, 8'h14, 8'h14, 8'h14, 8'h14, 8'h14, 8'h14,
		8'h3A, 8'h3A, 8'h9A, 8'h5A, 8'h11, 8'h11, 8'h11, 8'h00
	};
	localparam logic [7:0] LUT_BACK2_HI [16] = '{
		8'h05, 8'h05, 8'h05, 8'h05, 8'h05, 8'h05, 8'h05, 8'h05,
		8'h0D, 8'h0D, 8'h0D, 8'h0D, 8'h1D, 8'h0D, 8'hE7, 8'h00
	};
	localparam logic [7:0] LUT_BACK2_LO [16] = '{
		8'h3F, 8'h1F, 8'h0F, 8'h0F, 8'h0F, 8'h0F, 8'h0F, 8'h0F,
		8'h0F, 8'h0F, 8'h0F, 8'h0F, 8'h0F, 8'hCF, 8'h0F, 8'h0F
	};

	typedef struct packed {
		logic                       ok;
		logic [c8v_pkg::TAIL_W-1:0] tail;
	} verdict_t;

	typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_DENSE} rx_mode_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_axis_tvalid = 1'b0;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata = 8'h00;
	logic       s_axis_tlast = 1'b0;
	logic       m_axis_tvalid;
	logic       m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;

	// predictor state
	logic [7:0]                 prev_b = 8'h00;
	logic [7:0]                 prev2_b = 8'h00;
	logic [c8v_pkg::HIST_W-1:0] hs_hist = '0;
	logic                       err_sticky = 1'b0;

	verdict_t   verdict_q [$];
	verdict_t   want;
	logic [7:0] stream_buf [$];
	int         items_sent = 0;
	int         err_count = 0;
	int         cycle_cnt = 0;
	int         burst_left = 0;
	int         idle_len = 0;
	logic       holding = 1'b0;
	logic [7:0] rx_tick = 8'h00;
	rx_mode_t   rx_mode = RX_OPEN;
	event       hold_ev;

	cesu8_stream_validator u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == LIMIT_CYCLES) begin
			$display("** cesu8_stream_validator: FAILED **");
			$finish;
		end
	end

	task automatic track_byte(input logic [7:0] b, input logic last);
		logic [7:0]                 part;
		logic                       hs;
		logic                       ls;
		logic [c8v_pkg::HIST_W-1:0] marks;
		verdict_t                   v;
		part = LUT_BACK1[prev_b[7:4]] & LUT_BACK2_HI[prev2_b[7:4]] & LUT_BACK2_LO[prev2_b[3:0]];
		hs = part[7];
		ls = part[6];
		if ((part & LUT_CUR[b[7:4]]) != 8'h00 || b[7:4] == c8v_pkg::NIB_ILLEGAL ||
				hs_hist[2] != ls)
			err_sticky = 1'b1;
		if (last) begin
			marks = {hs_hist[1], hs_hist[0], hs};
			if (marks == c8v_pkg::MARK_BACK2)
				v.tail = c8v_pkg::TAIL_HS_BACK2;
			else if (marks == c8v_pkg::MARK_BACK1)
				v.tail = c8v_pkg::TAIL_HS_BACK1;
			else if (marks == c8v_pkg::MARK_CUR)
				v.tail = c8v_pkg::TAIL_HS_CUR;
			else if (prev_b[7:4] == c8v_pkg::NIB_THREE_BYTE)
				v.tail = c8v_pkg::TAIL_THREE;
			else if (b[7:6] == c8v_pkg::TOP_LEAD)
				v.tail = c8v_pkg::TAIL_LEAD;
			else
				v.tail = c8v_pkg::TAIL_NONE;
			v.ok = !err_sticky;
			verdict_q.push_back(v);
			prev_b = 8'h00;
			prev2_b = 8'h00;
			hs_hist = '0;
			err_sticky = 1'b0;
		end else begin
			prev2_b = prev_b;
			prev_b = b;
			hs_hist = {hs_hist[1:0], hs};
		end
	endtask

	task automatic send_byte(input logic [7:0] b, input logic last);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 48);
			idle_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
			if (idle_len != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (idle_len) @(posedge clk);
			end
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tlast <= last;
		do @(posedge clk); while (!s_axis_tready);
		track_byte(b, last);
		items_sent++;
	endtask

	task automatic send_stream();
		for (int i = 0; i < stream_buf.size(); i++)
			send_byte(stream_buf[i], i == stream_buf.size() - 1);
	endtask

	function automatic logic [7:0] cont_byte();
		return 8'($urandom_range(8'h80, 8'hBF));
	endfunction

	task automatic add_code_point();
		logic [7:0] lead;
		case ($urandom_range(0, 31))
		0, 1, 2, 3, 4, 5, 6, 7, 8, 9: begin
			stream_buf.push_back(8'($urandom_range(8'h00, 8'h7F)));
		end
		10, 11, 12, 13, 14, 15: begin
			stream_buf.push_back(8'($urandom_range(8'hC0, 8'hDF)));
			stream_buf.push_back(cont_byte());
		end
		16, 17: begin
			stream_buf.push_back(8'hE0);
			stream_buf.push_back(8'($urandom_range(8'hA0, 8'hBF)));
			stream_buf.push_back(cont_byte());
		end
		18, 19, 20, 21: begin
			lead = 8'($urandom_range(8'hE1, 8'hEF));
			stream_buf.push_back(lead);
			if (lead == 8'hED)
				stream_buf.push_back(8'($urandom_range(8'h80, 8'h9F)));
			else
				stream_buf.push_back(cont_byte());
			stream_buf.push_back(cont_byte());
		end
		22, 23, 24, 25, 30, 31: begin
			stream_buf.push_back(8'hED);
			stream_buf.push_back(8'($urandom_range(8'hA0, 8'hAF)));
			stream_buf.push_back(cont_byte());
			stream_buf.push_back(8'hED);
			stream_buf.push_back(8'($urandom_range(8'hB0, 8'hBF)));
			stream_buf.push_back(cont_byte());
		end
		26: begin
			stream_buf.push_back(8'hED);
			stream_buf.push_back(8'($urandom_range(8'hA0, 8'hAF)));
			stream_buf.push_back(cont_byte());
		end
		27: begin
			stream_buf.push_back(8'hED);
			stream_buf.push_back(8'($urandom_range(8'hB0, 8'hBF)));
			stream_buf.push_back(cont_byte());
		end
		28: begin
			stream_buf.push_back(8'($urandom_range(0, 255)));
		end
		default: begin
			stream_buf.push_back(8'($urandom_range(8'hF0, 8'hFF)));
			repeat (3) stream_buf.push_back(cont_byte());
		end
		endcase
	endtask

	task automatic test_edge_bytes();
		stream_buf = '{8'h00};
		send_stream();
		stream_buf = '{8'hFF};
		send_stream();
		stream_buf = '{8'h80, 8'h7F};
		send_stream();
		stream_buf = '{8'hC3};
		send_stream();
	endtask

	task automatic test_tail_lengths();
		stream_buf = '{8'hE4, 8'h80};
		send_stream();
		stream_buf = '{8'hED, 8'hA0, 8'h80};
		send_stream();
		stream_buf = '{8'hED, 8'hA0, 8'h80, 8'hED};
		send_stream();
		stream_buf = '{8'hED, 8'hA0, 8'h80, 8'hED, 8'hB0};
		send_stream();
		stream_buf = '{8'hED, 8'hAF, 8'hBF, 8'hED, 8'hBF, 8'h80};
		send_stream();
	endtask

	task automatic test_unpaired_surrogate();
		stream_buf = '{8'hED, 8'hB0, 8'h80};
		send_stream();
	endtask

	task automatic test_backpressure();
		-> hold_ev;
		repeat (40) begin
			stream_buf.delete();
			repeat ($urandom_range(1, 3)) stream_buf.push_back(8'($urandom_range(0, 255)));
			send_stream();
		end
	endtask

	task automatic test_random_streams();
		int goal;
		goal = items_sent + ITEMS_GOAL;
		while (items_sent < goal) begin
			stream_buf.delete();
			if ($urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(1, 8)) stream_buf.push_back(8'($urandom_range(0, 255)));
			end else begin
				repeat ($urandom_range(1, 10)) add_code_point();
				if ($urandom_range(0, 3) == 0 && stream_buf.size() > 1)
					void'(stream_buf.pop_back());
			end
			send_stream();
		end
	endtask

	always begin
		@(hold_ev);
		holding <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		holding <= 1'b0;
	end

	always @(posedge clk) begin
		rx_tick <= rx_tick + 8'd1;
		if (rx_tick[5:0] == 6'd0)
			rx_mode <= rx_mode_t'($urandom_range(0, 3));
		case (rx_mode)
		RX_OPEN:   m_axis_tready <= !holding;
		RX_COIN:   m_axis_tready <= !holding && ($urandom_range(0, 1) == 1);
		RX_SPARSE: m_axis_tready <= !holding && (rx_tick[1:0] == 2'd0);
		default:   m_axis_tready <= !holding && (rx_tick[1:0] != 2'd0);
		endcase
	end

	task automatic report_mismatch(input string msg);
		err_count++;
		if (err_count <= REPORT_MAX)
			$display("mismatch at cycle %0d: %s", cycle_cnt, msg);
	endtask

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (verdict_q.size() == 0) begin
				report_mismatch($sformatf("result beat with nothing expected, tdata=%h",
					m_axis_tdata));
			end else begin
				want = verdict_q.pop_front();
				if (m_axis_tdata[0] !== want.ok || m_axis_tdata[3:1] !== want.tail ||
						m_axis_tdata[7:4] !== 4'h0)
					report_mismatch($sformatf(
						"valid exp %0b got %0b, tail exp %0d got %0d, pad got %h",
						want.ok, m_axis_tdata[0], want.tail, m_axis_tdata[3:1],
						m_axis_tdata[7:4]));
			end
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_edge_bytes();
		test_tail_lengths();
		test_unpaired_surrogate();
		test_backpressure();
		test_random_streams();
		s_axis_tvalid <= 1'b0;
		while (verdict_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_count == 0 && verdict_q.size() == 0)
			$display("** cesu8_stream_validator: PASSED **");
		else
			$display("** cesu8_stream_validator: FAILED **");
		$finish;
	end

endmodule
